// ----- design/bbf_pkg.sv -----
// Shared types and constants of the box blur filter.
`timescale 1ns / 1ps
package bbf_pkg;
    localparam int PIX_W      = 8;
    localparam int NUM_CH     = 3;
    localparam int POS_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    typedef struct packed {
        logic accept;
        logic capture;
        logic update;
        logic div_step;
        logic out_load;
    } bbf_cmd_t;

    typedef struct packed {
        logic emit;
        logic div_last;
        logic out_free;
    } bbf_sts_t;
endpackage

// ----- design/bbf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bbf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- design/bbf_ctrl.sv -----
// Sequencer that steps one pixel through capture and update, and through divide and output when it completes a window.
`timescale 1ns / 1ps
module bbf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  bbf_pkg::bbf_sts_t sts,
    output bbf_pkg::bbf_cmd_t cmd
);
    import bbf_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CAPTURE = 3'd1;
    localparam logic [2:0] ST_UPDATE  = 3'd2;
    localparam logic [2:0] ST_DIVIDE  = 3'd3;
    localparam logic [2:0] ST_OUTPUT  = 3'd4;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) state_next = ST_CAPTURE;
            end
            ST_CAPTURE: begin
                cmd.capture = 1'b1;
                state_next  = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = sts.emit ? ST_DIVIDE : ST_IDLE;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) state_next = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                cmd.out_load = sts.out_free;
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

// ----- design/bbf_datapath.sv -----
// Counters, line store, column and window sums, mean divider and output register.
`timescale 1ns / 1ps
module bbf_datapath #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_RADIUS = 7
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [bbf_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [bbf_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic [bbf_pkg::S_TDATA_W-1:0]     s_tdata,
    input  bbf_pkg::bbf_cmd_t                 cmd,
    output bbf_pkg::bbf_sts_t                 sts,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bbf_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tlast
);
    import bbf_pkg::*;

    localparam int RING  = 2 * MAX_RADIUS + 1;
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int DW    = RW + 1;
    localparam int DQW   = 2 * DW;
    localparam int SW    = $clog2(RING);
    localparam int LS_DEPTH = RING * MAX_WIDTH;
    localparam int LAW   = $clog2(LS_DEPTH);
    localparam int CSW   = $clog2(RING * 255 + 1);
    localparam int WSW   = $clog2(RING * RING * 255 + 1);
    localparam int CMPW  = WSW + DQW + PIX_W;

    // Configuration registers.
    logic [2:0]            rad_reg;
    logic [CFG_DATA_W-1:0] wid_reg, hgt_reg;

    logic [RW-1:0] r_eff;
    logic [DW-1:0] d_val, two_r;
    logic [XW:0]   w_eff;
    logic [YW:0]   h_eff;
    logic [DQW-1:0] dsq;

    always_comb begin
        r_eff = (32'(rad_reg) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(rad_reg);
        if (wid_reg == '0) w_eff = (XW+1)'(1);
        else if (32'(wid_reg) > MAX_WIDTH) w_eff = (XW+1)'(MAX_WIDTH);
        else w_eff = (XW+1)'(wid_reg);
        if (hgt_reg == '0) h_eff = (YW+1)'(1);
        else if (32'(hgt_reg) > MAX_HEIGHT) h_eff = (YW+1)'(MAX_HEIGHT);
        else h_eff = (YW+1)'(hgt_reg);
        d_val = {r_eff, 1'b1};
        two_r = {r_eff, 1'b0};
        dsq   = DQW'(d_val) * DQW'(d_val);
    end

    logic restart;
    assign restart = cfg_wr_en && (cfg_wr_index == CFG_RADIUS ||
                                   cfg_wr_index == CFG_WIDTH ||
                                   cfg_wr_index == CFG_HEIGHT);

    // Position state.
    logic [XW-1:0] col_reg;
    logic [YW-1:0] row_reg;
    logic [SW-1:0] slot_reg;
    logic          last_col, last_row, last_slot;

    assign last_col  = ((XW+1)'(col_reg) + (XW+1)'(1)) == w_eff;
    assign last_row  = ((YW+1)'(row_reg) + (YW+1)'(1)) == h_eff;
    assign last_slot = (32'(slot_reg) + 32'd1) == 32'(d_val);

    logic row_full, col_full, emit_now;
    assign row_full = (YW+1)'(row_reg) >= (YW+1)'(d_val);
    assign col_full = (XW+1)'(col_reg) >= (XW+1)'(d_val);
    assign emit_now = ((YW+1)'(row_reg) >= (YW+1)'(two_r)) &&
                      ((XW+1)'(col_reg) >= (XW+1)'(two_r));

    // Memories.
    logic [LAW-1:0] ls_addr;
    logic [NUM_CH-1:0][PIX_W-1:0] pix_reg, ls_rdata;
    logic [XW-1:0] cs_raddr;
    logic [NUM_CH-1:0][CSW-1:0] cs_rdata, newcol_reg, newcol_next;

    assign ls_addr  = LAW'(32'(slot_reg) * MAX_WIDTH + 32'(col_reg));
    assign cs_raddr = cmd.capture ? XW'(col_reg - XW'(d_val)) : col_reg;

    bbf_ram #(.WIDTH(NUM_CH * PIX_W), .DEPTH(LS_DEPTH)) u_line_store (
        .aclk  (aclk),
        .we    (cmd.capture),
        .waddr (ls_addr),
        .wdata (pix_reg),
        .raddr (ls_addr),
        .rdata (ls_rdata)
    );

    bbf_ram #(.WIDTH(NUM_CH * CSW), .DEPTH(MAX_WIDTH)) u_col_sums (
        .aclk  (aclk),
        .we    (cmd.update),
        .waddr (col_reg),
        .wdata (newcol_reg),
        .raddr (cs_raddr),
        .rdata (cs_rdata)
    );

    // Window sums and divider.
    logic [NUM_CH-1:0][WSW-1:0]   win_reg, win_next, rem_reg;
    logic [NUM_CH-1:0][PIX_W-1:0] quo_reg;
    logic [2:0]                   k_reg;
    logic [NUM_CH-1:0][CMPW-1:0]  rem_wide;
    logic [CMPW-1:0]              cand;
    logic [NUM_CH-1:0]            ge;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            if (row_reg == '0) begin
                newcol_next[c] = CSW'(pix_reg[c]);
            end else begin
                newcol_next[c] = cs_rdata[c] + CSW'(pix_reg[c])
                               - (row_full ? CSW'(ls_rdata[c]) : CSW'(0));
            end
            win_next[c] = ((col_reg == '0) ? WSW'(0) : win_reg[c]) + WSW'(newcol_reg[c])
                        - (col_full ? WSW'(cs_rdata[c]) : WSW'(0));
        end
        cand = CMPW'(dsq) << k_reg;
        for (int c = 0; c < NUM_CH; c++) begin
            rem_wide[c] = CMPW'(rem_reg[c]);
            ge[c]       = rem_wide[c] >= cand;
        end
    end

    // Output register.
    logic              m_tvalid_reg;
    logic [POS_W-1:0]  orow_reg, ocol_reg;
    logic              olast_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic              m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rad_reg      <= 3'd1;
            wid_reg      <= CFG_DATA_W'(640);
            hgt_reg      <= CFG_DATA_W'(480);
            col_reg      <= '0;
            row_reg      <= '0;
            slot_reg     <= '0;
            win_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_wr_index)
                    CFG_RADIUS: rad_reg <= cfg_wr_data[2:0];
                    CFG_WIDTH:  wid_reg <= cfg_wr_data;
                    CFG_HEIGHT: hgt_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (restart) begin
                col_reg  <= '0;
                row_reg  <= '0;
                slot_reg <= '0;
                win_reg  <= '0;
            end else if (cmd.update) begin
                win_reg <= win_next;
                if (last_col) begin
                    col_reg <= '0;
                    if (last_row) begin
                        row_reg  <= '0;
                        slot_reg <= '0;
                    end else begin
                        row_reg  <= row_reg + YW'(1);
                        slot_reg <= last_slot ? SW'(0) : slot_reg + SW'(1);
                    end
                end else begin
                    col_reg <= col_reg + XW'(1);
                end
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pix_reg <= s_tdata;
        end
        if (cmd.capture) begin
            newcol_reg <= newcol_next;
        end
        if (cmd.update) begin
            rem_reg   <= win_next;
            quo_reg   <= '0;
            k_reg     <= 3'd7;
            orow_reg  <= POS_W'(32'(row_reg) - 32'(r_eff));
            ocol_reg  <= POS_W'(32'(col_reg) - 32'(r_eff));
            olast_reg <= last_col && last_row;
        end
        if (cmd.div_step) begin
            for (int c = 0; c < NUM_CH; c++) begin
                if (ge[c]) rem_reg[c] <= WSW'(rem_wide[c] - cand);
                quo_reg[c] <= {quo_reg[c][PIX_W-2:0], ge[c]};
            end
            k_reg <= k_reg - 3'd1;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= M_TDATA_W'({quo_reg[2], quo_reg[1], quo_reg[0], ocol_reg, orow_reg});
            m_tlast_reg <= olast_reg;
        end
    end

    assign sts.emit     = emit_now;
    assign sts.div_last = (k_reg == 3'd0);
    assign sts.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;
    assign m_tlast      = m_tlast_reg;
endmodule

// ----- design/box_blur_filter_core.sv -----
// An accepted pixel passes the capture and update states; one that completes a window
// then runs the 8-step shift-subtract divider and waits in the output state until the output register is free.
// The next pixel is taken only after that; the column sum memory is read-modify-written.
// Reset (aresetn low, synchronous) clears counters and window sums and loads
// radius 1, 640 x 480; the line store and column sums need no clearing.
`timescale 1ns / 1ps
module box_blur_filter_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_RADIUS = 7
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bbf_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [bbf_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // chan_a[7:0], chan_b[15:8], chan_c[23:16]
    input  logic [bbf_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_row[9:0], out_col[19:10], mean_a[27:20], mean_b[35:28], mean_c[43:36], zero pad
    output logic [bbf_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast
);
    import bbf_pkg::*;

    bbf_cmd_t cmd;
    bbf_sts_t sts;

    bbf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bbf_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tdata      (s_tdata),
        .cmd          (cmd),
        .sts          (sts),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

    // One pixel at a time: the block closes its input right after a beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a pixel is in flight");

    // A result needs capture, update and divide, so it never follows an accept directly.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result appeared too soon after an input beat");

    // The divider only runs for a pixel that completes a window.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.update && !sts.emit) |=> !cmd.div_step)
        else $error("divider started for a border pixel");
endmodule

// ----- verif/box_blur_filter_core_test.sv -----
// Self-checking testbench for the box blur filter core with a built-in window-mean predictor.
`timescale 1ns / 1ps
module box_blur_filter_core_test;
    import bbf_pkg::*;

    localparam int MAXW = 1024;
    localparam int MAXH = 1024;
    localparam int MAXR = 7;
    localparam int RING = 2 * MAXR + 1;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [7:0]       mean_a;
        logic [7:0]       mean_b;
        logic [7:0]       mean_c;
        logic             frame_end;
    } blur_beat_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = CFG_RADIUS;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic m_tlast;

    box_blur_filter_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    initial forever #2 aclk = ~aclk;

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    // Predictor state, mirroring the block's line ring and running sums.
    logic [23:0] ring_pix [0:RING*MAXW-1];
    int unsigned col_sum [0:MAXW-1][0:2];
    int unsigned win_sum [0:2];
    int unsigned cur_row, cur_col;
    int unsigned radius_reg = 1, width_reg = 640, height_reg = 480;

    blur_beat_t mean_queue [$];
    int errors = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;

    task automatic predict_pixel(input logic [23:0] pix);
        int unsigned r, w, h, d, y, x, idx;
        int unsigned s, old;
        blur_beat_t b;
        r = (radius_reg > MAXR) ? MAXR : radius_reg;
        w = (width_reg == 0) ? 1 : ((width_reg > MAXW) ? MAXW : width_reg);
        h = (height_reg == 0) ? 1 : ((height_reg > MAXH) ? MAXH : height_reg);
        d = 2 * r + 1;
        y = (cur_row >= h) ? 0 : cur_row;
        x = (cur_col >= w) ? 0 : cur_col;
        idx = (y % d) * MAXW + x;
        for (int c = 0; c < 3; c++) begin
            s = 32'(pix[8*c +: 8]);
            old = 32'(ring_pix[idx][8*c +: 8]);
            if (y == 0) begin
                col_sum[x][c] = s;
            end else begin
                col_sum[x][c] += s;
                if (y >= d) col_sum[x][c] -= old;
            end
            if (x == 0) win_sum[c] = 0;
            win_sum[c] += col_sum[x][c];
            if (x >= d) win_sum[c] -= col_sum[x-d][c];
        end
        ring_pix[idx] = pix;
        if (y >= 2 * r && x >= 2 * r) begin
            b.row = POS_W'(y - r);
            b.col = POS_W'(x - r);
            b.mean_a = 8'(win_sum[0] / (d * d));
            b.mean_b = 8'(win_sum[1] / (d * d));
            b.mean_c = 8'(win_sum[2] / (d * d));
            b.frame_end = (y == h - 1 && x == w - 1);
            mean_queue.push_back(b);
        end
        x++;
        if (x >= w) begin
            x = 0;
            y++;
            if (y >= h) y = 0;
        end
        cur_col = x;
        cur_row = y;
    endtask

    // Waits for all outstanding means, then past the block's pipeline, before a write.
    task automatic drain;
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (mean_queue.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        drain();
        cfg_wr_en = 1'b1;
        cfg_wr_index = idx;
        cfg_wr_data = val[CFG_DATA_W-1:0];
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        if (idx == CFG_RADIUS) radius_reg = val & 32'h7;
        else if (idx == CFG_WIDTH) width_reg = val & 32'h7FF;
        else height_reg = val & 32'h7FF;
        cur_row = 0;
        cur_col = 0;
        win_sum = '{0, 0, 0};
    endtask

    task automatic set_geometry(input int unsigned r, input int unsigned w, input int unsigned h);
        write_reg(CFG_RADIUS, r);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    // Offers one pixel and returns once it is accepted; tvalid stays high afterwards.
    task automatic send_pixel(input logic [23:0] pix);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = pix;
        do @(posedge aclk); while (!s_tready);
        predict_pixel(pix);
    endtask

    function automatic logic [23:0] rand_pixel;
        logic [23:0] p;
        p = 24'($urandom);
        case ($urandom_range(7))
            0: p = '0;
            1: p = '1;
            default: ;
        endcase
        return p;
    endfunction

    // Result side: random stalls plus an optional long hold-off.
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        blur_beat_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.row = m_tdata[9:0];
            got.col = m_tdata[19:10];
            got.mean_a = m_tdata[27:20];
            got.mean_b = m_tdata[35:28];
            got.mean_c = m_tdata[43:36];
            got.frame_end = m_tlast;
            if (mean_queue.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %p", $time, got);
                errors++;
            end else begin
                want = mean_queue.pop_front();
                if (got != want) begin
                    $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
                    errors++;
                end
            end
        end
    end

    task automatic test_single_pixel_frames;
        // Radius zero on a 1 x 1 frame: every pixel is its own window and ends a frame.
        set_geometry(0, 1, 1);
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h00FF80);
        send_pixel(24'hA5015A);
    endtask

    task automatic test_window_extremes;
        set_geometry(1, 3, 3);
        repeat (9) send_pixel(24'hFFFFFF);
        repeat (9) send_pixel(24'h000000);
    endtask

    task automatic test_dimension_clamps;
        // Zero width and height act as 1; oversize values saturate.
        set_geometry(0, 0, 0);
        send_pixel(24'h123456);
        send_pixel(24'hFEDCBA);
        set_geometry(0, 2047, 2);
        repeat (4) send_pixel(rand_pixel());
    endtask

    task automatic test_small_image;
        // Smaller than the window: no output; window-sized: one mean. Both frames wrap.
        set_geometry(2, 3, 3);
        repeat (20) send_pixel(rand_pixel());
        set_geometry(7, 15, 15);
        repeat (230) send_pixel(rand_pixel());
    endtask

    task automatic test_random_frames;
        int unsigned r, w, h, n, sent;
        for (int mode = 0; mode < 4; mode++) begin
            send_idle_pct = (mode == 1 || mode == 3) ? ((mode == 1) ? 87 : 27) : 0;
            stall_pct = (mode == 2 || mode == 3) ? ((mode == 2) ? 87 : 27) : 0;
            sent = 0;
            while (sent < 160) begin
                r = $urandom_range(MAXR);
                w = $urandom_range(2 * r + 12, 1);
                h = $urandom_range(2 * r + 6, 1);
                if ($urandom_range(9) == 0) w = $urandom_range(2047, 0);
                if ($urandom_range(9) == 0) h = $urandom_range(2047, 0);
                set_geometry(r, w, h);
                // Stop well short of a big frame so large widths stay cheap.
                n = $urandom_range(120, 20);
                if (mode == 0 && sent == 0) hold_cycles = 300;
                repeat (n) send_pixel(rand_pixel());
                sent += n;
            end
        end
        send_idle_pct = 0;
        stall_pct = 0;
        // A full 1024-wide row reaches the last columns of the line store.
        set_geometry(0, 1024, 1);
        repeat (1024) send_pixel(rand_pixel());
    endtask

    initial begin
        for (int i = 0; i < RING * MAXW; i++) ring_pix[i] = '0;
        for (int i = 0; i < MAXW; i++) col_sum[i] = '{0, 0, 0};
        win_sum = '{0, 0, 0};
        cur_row = 0;
        cur_col = 0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        test_single_pixel_frames();
        test_window_extremes();
        test_dimension_clamps();
        test_small_image();
        test_random_frames();
        drain();
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

// ----- box_blur_filter_core.f -----
design/bbf_pkg.sv
design/bbf_ram.sv
design/bbf_ctrl.sv
design/bbf_datapath.sv
design/box_blur_filter_core.sv
verif/box_blur_filter_core_test.sv
